>>> sv/kll_pkg.sv
// Shared types, constants and helpers for the keyword lexer tokenizer.
package kll_pkg;

   localparam int MATCH_CHARS = 8;
   localparam int OFFSET_BITS = 16;
   localparam int MATCH_BITS  = MATCH_CHARS * 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam int KW_COUNT = 14;

   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_FIELD_BITS = 4 + OFFSET_BITS + 8 + 8 + 8;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      KIND_OP      = 3'd0,
      KIND_SEP     = 3'd1,
      KIND_INT     = 3'd2,
      KIND_REAL    = 3'd3,
      KIND_KEYWORD = 3'd4,
      KIND_IDENT   = 3'd5,
      KIND_UNKNOWN = 3'd6
   } kind_type;

   // one token record
   typedef struct packed {
      logic                   last;
      kind_type               kind;
      logic [3:0]             kw_index;
      logic [OFFSET_BITS-1:0] start;
      logic [7:0]             length;
      logic [7:0]             first_char;
      logic [7:0]             second_char;
   } rec_type;

   // all tokens raised by one input byte: one or two records
   typedef struct packed {
      logic    two;
      rec_type r0;
      rec_type r1;
   } entry_type;

   // keyword spellings, right aligned in 64 bits: first character in the highest used byte
   localparam logic [63:0] KW_LIT [KW_COUNT] = '{
      64'("int"), 64'("function"), 64'("bool"), 64'("real"), 64'("if"),
      64'("else"), 64'("fi"), 64'("return"), 64'("put"), 64'("get"),
      64'("while"), 64'("endwhile"), 64'("true"), 64'("false")
   };

   localparam logic [7:0] KW_LEN [KW_COUNT] = '{
      8'd3, 8'd8, 8'd4, 8'd4, 8'd2, 8'd4, 8'd2, 8'd6, 8'd3, 8'd3,
      8'd5, 8'd8, 8'd4, 8'd5
   };

   // keyword laid out as the match buffer holds it: byte j at bits [8j+7:8j], zero padded
   function automatic logic [MATCH_BITS-1:0] kw_text(input int k);
      logic [MATCH_BITS-1:0] t;
      int                    n;
      t = '0;
      n = int'(KW_LEN[k]);
      for (int j = 0; j < 8; j++) begin
         if (j < n) begin
            t[8*j +: 8] = KW_LIT[k][8*(n-1-j) +: 8];
         end
      end
      return t;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c == "=" || c == "!" || c == ">" || c == "<" ||
             c == "*" || c == "/" || c == "-" || c == "+";
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c == "(" || c == ")" || c == "{" || c == "}";
   endfunction

endpackage

>>> sv/kll_front.sv
// Scanner front end: tracks the open lexeme and builds the token records for each byte.
module kll_front
   import kll_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output logic                   push,
   output entry_type              entry
);

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_IDENT  = 5'b00010,
      MODE_NUMBER = 5'b00100,
      MODE_OP     = 5'b01000,
      MODE_SKIP   = 5'b10000
   } mode_type;

   mode_type               mode_ff,  mode_in;
   logic [MATCH_BITS-1:0]  buf_ff,   buf_in;
   logic [7:0]             len_ff,   len_in;
   logic                   dot_ff,   dot_in;
   logic [7:0]             pend_ff,  pend_in;
   logic [OFFSET_BITS-1:0] pos_ff,   pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;

   rec_type    recs [2];
   logic [1:0] cnt;
   logic       fresh;

   function automatic rec_type one_rec(input kind_type k, input logic [OFFSET_BITS-1:0] s,
                                       input logic [7:0] l, input logic [7:0] c1,
                                       input logic [7:0] c2);
      rec_type r;
      r.last        = 1'b0;
      r.kind        = k;
      r.kw_index    = 4'd0;
      r.start       = s;
      r.length      = l;
      r.first_char  = c1;
      r.second_char = c2;
      return r;
   endfunction

   // record for the lexeme that is open in mode m
   function automatic rec_type close_rec(input mode_type m, input logic [MATCH_BITS-1:0] b,
                                         input logic [7:0] l, input logic d,
                                         input logic [7:0] p,
                                         input logic [OFFSET_BITS-1:0] s);
      rec_type r;
      logic    found;
      r     = one_rec(KIND_IDENT, s, l, b[7:0], 8'd0);
      found = 1'b0;
      if (m == MODE_IDENT) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (!found && l == KW_LEN[k] && b == kw_text(k)) begin
               found      = 1'b1;
               r.kind     = KIND_KEYWORD;
               r.kw_index = 4'(k);
            end
         end
      end else if (m == MODE_NUMBER) begin
         r.kind = d ? KIND_REAL : KIND_INT;
      end else begin
         r = one_rec(KIND_OP, s, 8'd1, p, 8'd0);
      end
      return r;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      buf_in   = buf_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      pend_in  = pend_ff;
      start_in = start_ff;
      pos_in   = pos_ff + 1'b1;
      recs[0]  = '0;
      recs[1]  = '0;
      cnt      = 2'd0;
      fresh    = 1'b1;

      unique case (mode_ff)
         MODE_SKIP: begin
            if (in_byte == "]") begin
               mode_in = MODE_IDLE;
            end
            fresh = 1'b0;
         end
         MODE_OP: begin
            if (((pend_ff == "<" || pend_ff == ">") && in_byte == "=") ||
                (pend_ff == "=" && (in_byte == ">" || in_byte == "<"))) begin
               recs[0] = one_rec(KIND_OP, start_ff, 8'd2, pend_ff, in_byte);
               fresh   = 1'b0;
            end else begin
               recs[0] = close_rec(mode_ff, buf_ff, len_ff, dot_ff, pend_ff, start_ff);
            end
            cnt     = 2'd1;
            mode_in = MODE_IDLE;
         end
         MODE_IDENT, MODE_NUMBER: begin
            if (is_digit(in_byte) ||
                (mode_ff == MODE_IDENT && is_alpha(in_byte)) ||
                (mode_ff == MODE_NUMBER && in_byte == ".")) begin
               for (int j = 0; j < MATCH_CHARS; j++) begin
                  if (len_ff == 8'(j)) begin
                     buf_in[8*j +: 8] = in_byte;
                  end
               end
               if (len_ff != 8'hFF) begin
                  len_in = len_ff + 8'd1;
               end
               if (in_byte == ".") begin
                  dot_in = 1'b1;
               end
               fresh = 1'b0;
            end else begin
               recs[0] = close_rec(mode_ff, buf_ff, len_ff, dot_ff, pend_ff, start_ff);
               cnt     = 2'd1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_IDLE: begin
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      if (fresh) begin
         if (is_space(in_byte)) begin
         end else if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == ".") begin
            buf_in        = '0;
            buf_in[7:0]   = in_byte;
            len_in        = 8'd1;
            dot_in        = (in_byte == ".");
            start_in      = pos_ff;
            mode_in       = is_alpha(in_byte) ? MODE_IDENT : MODE_NUMBER;
         end else if (in_byte == "<" || in_byte == ">" || in_byte == "=") begin
            pend_in  = in_byte;
            start_in = pos_ff;
            mode_in  = MODE_OP;
         end else if (in_byte == "[") begin
            mode_in = MODE_SKIP;
         end else begin
            recs[cnt[0]] = one_rec(is_op(in_byte)  ? KIND_OP  :
                                   is_sep(in_byte) ? KIND_SEP : KIND_UNKNOWN,
                                   pos_ff, 8'd1, in_byte, 8'd0);
            cnt = cnt + 2'd1;
         end
      end

      // end of input: flush whatever is still open
      if (in_last) begin
         if (mode_in == MODE_IDENT || mode_in == MODE_NUMBER || mode_in == MODE_OP) begin
            recs[cnt[0]] = close_rec(mode_in, buf_in, len_in, dot_in, pend_in, start_in);
            cnt = cnt + 2'd1;
         end
         mode_in = MODE_IDLE;
      end
   end

   always_comb begin
      entry         = '0;
      entry.two     = cnt[1];
      entry.r0      = recs[0];
      entry.r1      = recs[1];
      entry.r0.last = !cnt[1];
      entry.r1.last = 1'b1;
      push          = fire && (cnt != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         buf_ff   <= '0;
         len_ff   <= '0;
         dot_ff   <= 1'b0;
         pend_ff  <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         buf_ff   <= buf_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
      end
   end

endmodule

>>> sv/kll_queue.sv
// Short queue of per-byte token groups between scanner and output stage.
module kll_queue
   import kll_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   // depth is a power of two, so the pointers wrap on their own
   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, rd_ff;
   logic [QPTR_BITS:0]   cnt_ff;

   assign head  = mem_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

>>> sv/kll_back.sv
// Output stage: holds one token group and hands its records out one word at a time.
module kll_back
   import kll_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      empty,
   output logic      pop,
   output logic      out_valid,
   input  logic      out_ready,
   output rec_type   out_rec
);

   entry_type cur_ff;
   logic      valid_ff;
   logic      sel_ff;
   logic      advance;
   logic      second_next;

   assign advance     = !valid_ff || out_ready;
   assign second_next = valid_ff && !sel_ff && cur_ff.two;
   assign pop         = advance && !second_next && !empty;
   assign out_valid   = valid_ff;
   assign out_rec     = sel_ff ? cur_ff.r1 : cur_ff.r0;

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else if (advance) begin
         if (second_next) begin
            sel_ff <= 1'b1;
         end else begin
            sel_ff   <= 1'b0;
            valid_ff <= !empty;
         end
      end
   end

endmodule

>>> sv/keyword_lexer_tokenizer.sv
// Top level of the keyword lexer tokenizer: scanner, token queue and output stage.
//
// Source text goes in one byte per word on the req_ side, with req_tlast set on the final
// byte; token records come out on the rsp_ side, one per word, with rsp_tlast on the last
// token caused by a given byte (a byte causes zero, one or two tokens). The scanner takes
// a byte every cycle while the four-entry token queue has room, and the output stage hands
// out one token per cycle, so a text runs at one byte per cycle except where bytes raising
// two tokens come faster than the output can drain them or the rsp_ side holds off; then
// the queue fills and req_tready drops until a group leaves it. A taken byte's tokens are
// written into the token queue and then loaded into the output stage's register before
// they show on rsp_. The byte position counter is OFFSET_BITS wide, wraps, and is not
// cleared by end of input.
module keyword_lexer_tokenizer
   import kll_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [7:0] in_byte
   input  logic                     req_tlast,   // end_of_input
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // keyword_index, start_offset, token_length, first_char, second_char, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [2:0]               rsp_tuser,   // token_kind
   output logic                     rsp_tlast    // last_of_run
);

   logic      req_fire;
   logic      q_push, q_pop, q_empty, q_full;
   entry_type q_in, q_head;
   rec_type   out_rec;

   // the scanner only stalls when the queue cannot take a group
   assign req_tready = !q_full;
   assign req_fire   = req_tvalid && req_tready;

   kll_front u_front (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .in_byte (req_tdata[7:0]),
      .in_last (req_tlast),
      .push    (q_push),
      .entry   (q_in)
   );

   kll_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   kll_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tdata = RSP_DATA_BITS'({out_rec.second_char, out_rec.first_char,
                                      out_rec.length, out_rec.start, out_rec.kw_index});
   assign rsp_tuser = out_rec.kind;
   assign rsp_tlast = out_rec.last;

   // a group is never written into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("token group pushed into full queue");

   // keyword index is only carried by keywords
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tuser != KIND_KEYWORD |-> out_rec.kw_index == 4'd0)
      else $error("keyword index on non-keyword token");

   // only a two-byte operator carries a second character
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && out_rec.second_char != 8'd0 |->
                    rsp_tuser == KIND_OP && out_rec.length == 8'd2)
      else $error("second character on a token that is not a two-byte operator");

   // the scanner only emits when a byte is taken
   assert property (@(posedge clock) disable iff (reset) q_push |-> req_fire)
      else $error("token group without an accepted byte");

endmodule
